// ----- rtl/lik_pkg.sv -----
// shared constants, beat types and the arctangent table for the leg ik pipeline
// no dependencies
package lik_pkg;

    localparam int SQRT_STEPS   = 32;
    localparam int CORDIC_STEPS = 17;
    localparam int NORM_STAGES  = 4;
    localparam int ATAN_LAT     = NORM_STAGES + CORDIC_STEPS;
    localparam int FRONT_STAGES = 6;
    localparam int BACK_STAGES  = 3;
    localparam int LATENCY      = FRONT_STAGES + SQRT_STEPS + ATAN_LAT + BACK_STAGES;
    localparam int SIDE_DEPTH   = SQRT_STEPS + ATAN_LAT + 1;

    localparam int ATAN_IN_W = 36;
    localparam int NORM_W    = 33;
    localparam int CORDIC_W  = 35;
    localparam int ANGLE_W   = 20;
    localparam int SUM_W     = 23;

    localparam logic signed [ANGLE_W-1:0] HALF_PI_Q16 = 20'sd102944;
    localparam logic signed [SUM_W-1:0]   PI_Q16      = 23'sd205887;
    localparam logic signed [SUM_W-1:0]   TWO_PI_Q16  = 23'sd411774;

    localparam logic [15:0] HIP_RESET   = 16'd5243;
    localparam logic [15:0] THIGH_RESET = 16'd13959;
    localparam logic [15:0] CALF_RESET  = 16'd13959;

    typedef enum logic [1:0] {
        CFG_HIP   = 2'd0,
        CFG_THIGH = 2'd1,
        CFG_CALF  = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [63:0] rad;
        logic [34:0] rem;
        logic [31:0] root;
    } sqrt_beat_t;

    typedef struct packed {
        logic signed [CORDIC_W-1:0] x;
        logic signed [CORDIC_W-1:0] y;
        logic signed [ANGLE_W-1:0]  z;
        logic                       zero;
    } cordic_beat_t;

    function automatic logic signed [ANGLE_W-1:0] atan_entry(input logic [4:0] idx);
        logic signed [ANGLE_W-1:0] v;
        case (idx)
            5'd0:    v = 20'sd51472;
            5'd1:    v = 20'sd30385;
            5'd2:    v = 20'sd16055;
            5'd3:    v = 20'sd8150;
            5'd4:    v = 20'sd4091;
            5'd5:    v = 20'sd2047;
            5'd6:    v = 20'sd1024;
            5'd7:    v = 20'sd512;
            5'd8:    v = 20'sd256;
            5'd9:    v = 20'sd128;
            5'd10:   v = 20'sd64;
            5'd11:   v = 20'sd32;
            5'd12:   v = 20'sd16;
            5'd13:   v = 20'sd8;
            5'd14:   v = 20'sd4;
            5'd15:   v = 20'sd2;
            5'd16:   v = 20'sd1;
            default: v = 20'sd0;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/lik_sqrt_cell.sv -----
// one digit step of the integer square root chain
// depends on lik_pkg
module lik_sqrt_cell (
    input  logic                clk,
    input  lik_pkg::sqrt_beat_t beat_in,
    output lik_pkg::sqrt_beat_t beat_out
);

    lik_pkg::sqrt_beat_t beat_reg;
    lik_pkg::sqrt_beat_t beat_next;
    logic [34:0] rem_shift;
    logic [34:0] trial;
    logic        fits;

    always_comb
    begin
        rem_shift = {beat_in.rem[32:0], beat_in.rad[63:62]};
        trial     = {1'b0, beat_in.root, 2'b01};
        fits      = (rem_shift >= trial);
        beat_next.rad  = {beat_in.rad[61:0], 2'b00};
        beat_next.rem  = fits ? (rem_shift - trial) : rem_shift;
        beat_next.root = {beat_in.root[30:0], fits};
    end

    always_ff @(posedge clk)
    begin
        beat_reg <= beat_next;
    end

    assign beat_out = beat_reg;

endmodule

// ----- rtl/lik_sqrt.sv -----
// floor square root of a 64-bit word as a chain of digit cells
// depends on lik_pkg and lik_sqrt_cell
module lik_sqrt (
    input  logic        clk,
    input  logic [63:0] radicand,
    output logic [31:0] root
);

    lik_pkg::sqrt_beat_t beats [0:lik_pkg::SQRT_STEPS];

    assign beats[0].rad  = radicand;
    assign beats[0].rem  = '0;
    assign beats[0].root = '0;

    for (genvar i = 0; i < lik_pkg::SQRT_STEPS; i++)
    begin : g_cell
        lik_sqrt_cell u_cell (
            .clk      (clk),
            .beat_in  (beats[i]),
            .beat_out (beats[i+1])
        );
    end

    assign root = beats[lik_pkg::SQRT_STEPS].root;

endmodule

// ----- rtl/lik_cordic_cell.sv -----
// one vectoring rotation of the cordic chain
// depends on lik_pkg
module lik_cordic_cell (
    input  logic                  clk,
    input  logic [4:0]            step,
    input  lik_pkg::cordic_beat_t beat_in,
    output lik_pkg::cordic_beat_t beat_out
);

    lik_pkg::cordic_beat_t beat_reg;
    lik_pkg::cordic_beat_t beat_next;
    logic signed [lik_pkg::CORDIC_W-1:0] x_sh;
    logic signed [lik_pkg::CORDIC_W-1:0] y_sh;

    always_comb
    begin
        x_sh = beat_in.x >>> step;
        y_sh = beat_in.y >>> step;
        beat_next.zero = beat_in.zero;
        if (beat_in.y > 0)
        begin
            beat_next.x = beat_in.x + y_sh;
            beat_next.y = beat_in.y - x_sh;
            beat_next.z = beat_in.z + lik_pkg::atan_entry(step);
        end
        else
        begin
            beat_next.x = beat_in.x - y_sh;
            beat_next.y = beat_in.y + x_sh;
            beat_next.z = beat_in.z - lik_pkg::atan_entry(step);
        end
    end

    always_ff @(posedge clk)
    begin
        beat_reg <= beat_next;
    end

    assign beat_out = beat_reg;

endmodule

// ----- rtl/lik_atan2.sv -----
// atan2 in q.16: four normalizing stages then a chain of cordic cells
// depends on lik_pkg and lik_cordic_cell
module lik_atan2 (
    input  logic                                 clk,
    input  logic signed [lik_pkg::ATAN_IN_W-1:0] y_in,
    input  logic signed [lik_pkg::ATAN_IN_W-1:0] x_in,
    output logic signed [lik_pkg::ANGLE_W-1:0]   angle
);

    localparam int IW = lik_pkg::ATAN_IN_W;
    localparam int NW = lik_pkg::NORM_W;
    localparam int CW = lik_pkg::CORDIC_W;

    // stage 1: magnitude
    logic signed [IW-1:0] n1_x_reg, n1_y_reg;
    logic [IW-1:0]        n1_mag_reg, mag_next, ax, ay;
    logic                 n1_zero_reg;
    // stage 2: bit length
    logic signed [IW-1:0] n2_x_reg, n2_y_reg;
    logic [5:0]           n2_len_reg, len_next;
    logic                 n2_zero_reg;
    // stage 3: shifted candidates
    logic signed [NW-1:0] n3_x0_reg, n3_y0_reg, n3_x1_reg, n3_y1_reg;
    logic signed [NW-1:0] x0_next, y0_next, x1_next, y1_next;
    logic                 n3_zero_reg;
    logic [5:0]           lsh, rsh;
    // stage 4: pick and fold into the right half plane
    lik_pkg::cordic_beat_t n4_reg, n4_next;
    logic [NW-1:0]         m0x, m0y;
    logic signed [NW-1:0]  sx, sy;
    logic signed [CW-1:0]  ex, ey;

    lik_pkg::cordic_beat_t beats [0:lik_pkg::CORDIC_STEPS];

    always_comb
    begin
        ax = x_in[IW-1] ? IW'(-x_in) : x_in;
        ay = y_in[IW-1] ? IW'(-y_in) : y_in;
        mag_next = (ax > ay) ? ax : ay;
    end

    always_comb
    begin
        len_next = '0;
        for (int i = 0; i < IW; i++)
        begin
            if (n1_mag_reg[i])
            begin
                len_next = 6'(i + 1);
            end
        end
    end

    always_comb
    begin
        lsh = 6'd31 - n2_len_reg;
        rsh = n2_len_reg - 6'd31;
        if (n2_len_reg <= 6'd31)
        begin
            x0_next = NW'(n2_x_reg <<< lsh);
            y0_next = NW'(n2_y_reg <<< lsh);
            x1_next = x0_next;
            y1_next = y0_next;
        end
        else
        begin
            // floor shifts of negatives can leave the magnitude at 2^31, keep one more
            x0_next = NW'(n2_x_reg >>> rsh);
            y0_next = NW'(n2_y_reg >>> rsh);
            x1_next = NW'(n2_x_reg >>> (rsh + 6'd1));
            y1_next = NW'(n2_y_reg >>> (rsh + 6'd1));
        end
    end

    always_comb
    begin
        m0x = n3_x0_reg[NW-1] ? NW'(-n3_x0_reg) : n3_x0_reg;
        m0y = n3_y0_reg[NW-1] ? NW'(-n3_y0_reg) : n3_y0_reg;
        if ((m0x[NW-1:31] != '0) || (m0y[NW-1:31] != '0))
        begin
            sx = n3_x1_reg;
            sy = n3_y1_reg;
        end
        else
        begin
            sx = n3_x0_reg;
            sy = n3_y0_reg;
        end
        ex = CW'(sx);
        ey = CW'(sy);
        n4_next.zero = n3_zero_reg;
        if (ex < 0)
        begin
            if (ey >= 0)
            begin
                n4_next.x = ey;
                n4_next.y = -ex;
                n4_next.z = lik_pkg::HALF_PI_Q16;
            end
            else
            begin
                n4_next.x = -ey;
                n4_next.y = ex;
                n4_next.z = -lik_pkg::HALF_PI_Q16;
            end
        end
        else
        begin
            n4_next.x = ex;
            n4_next.y = ey;
            n4_next.z = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        n1_x_reg    <= x_in;
        n1_y_reg    <= y_in;
        n1_mag_reg  <= mag_next;
        n1_zero_reg <= (x_in == '0) && (y_in == '0);
        n2_x_reg    <= n1_x_reg;
        n2_y_reg    <= n1_y_reg;
        n2_len_reg  <= len_next;
        n2_zero_reg <= n1_zero_reg;
        n3_x0_reg   <= x0_next;
        n3_y0_reg   <= y0_next;
        n3_x1_reg   <= x1_next;
        n3_y1_reg   <= y1_next;
        n3_zero_reg <= n2_zero_reg;
        n4_reg      <= n4_next;
    end

    assign beats[0] = n4_reg;

    for (genvar i = 0; i < lik_pkg::CORDIC_STEPS; i++)
    begin : g_cell
        lik_cordic_cell u_cell (
            .clk      (clk),
            .step     (5'(i)),
            .beat_in  (beats[i]),
            .beat_out (beats[i+1])
        );
    end

    assign angle = beats[lik_pkg::CORDIC_STEPS].zero ? '0 : beats[lik_pkg::CORDIC_STEPS].z;

endmodule

// ----- rtl/leg_inverse_kinematics.sv -----
// leg inverse kinematics: foot target in, three joint angles out
// a beat accepted at one edge reaches the outputs together with done after passing every
// stage below; one item per cycle sustained, busy is never raised
// stages: front arithmetic (6), sqrt digit chain (32), cordic with normalizing (21), output (3)
// reset clears the valid pipeline and done, loads the default link lengths; no result stall
// depends on lik_pkg, lik_sqrt, lik_atan2
module leg_inverse_kinematics (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [19:0] foot_x,
    input  logic signed [19:0] foot_y,
    input  logic signed [19:0] foot_z,
    input  logic               is_right,
    output logic               done,
    output logic signed [15:0] hip_angle,
    output logic signed [15:0] thigh_angle,
    output logic signed [15:0] knee_angle,
    output logic               unreachable,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    localparam int AW = lik_pkg::ATAN_IN_W;
    localparam int SW = lik_pkg::SUM_W;

    typedef struct packed {
        logic signed [19:0] x;
        logic signed [19:0] y;
        logic signed [19:0] z;
        logic               right;
        logic [15:0]        h;
        logic [31:0]        t2;
        logic signed [34:0] n;
        logic               bad;
    } side_t;

    logic [15:0] hip_len_reg, thigh_len_reg, calf_len_reg;
    logic [lik_pkg::LATENCY-1:0] vld_reg;

    // front stages
    side_t side1_reg, side2_reg, side3_reg, side4_reg, side5_reg;
    side_t side3_next, side4_next;
    logic [38:0] xx1_reg, yy1_reg, zz1_reg;
    logic [31:0] h2_1_reg, c2_1_reg, tc1_reg;
    logic signed [39:0] xx_full, yy_full, zz_full;
    logic [39:0] ryz2_2_reg;
    logic [40:0] r2_2_reg;
    logic [33:0] hsum_2_reg;
    logic [32:0] d_2_reg, d_3_reg, d_4_reg;
    logic [31:0] h2_2_reg;
    logic [39:0] radw_3_reg, radw_4_reg, radw_5_reg, radw_6_reg;
    logic signed [41:0] n_3_reg;
    logic signed [34:0] dm_full, dp_full;
    logic [31:0] dm_5_reg, dp_5_reg;
    logic [63:0] prod_6_reg;

    side_t side_pipe [0:lik_pkg::SIDE_DEPTH-1];
    side_t side_a, side_z;

    logic [31:0] s_root, w_root;
    logic [19:0] w_val;
    logic signed [AW-1:0] al_y, al_x, be_y, be_x, ga_y, ga_x, ps_y, ps_x, ph_y, ph_x;
    logic signed [AW-1:0] psi_num;
    logic signed [lik_pkg::ANGLE_W-1:0] alpha, beta, gamma_a, psi, phi;

    logic signed [SW-1:0] hip_sum_reg, thigh_sum_reg, knee_sum_reg;
    logic signed [SW-1:0] hip_sum_next, thigh_sum_next, knee_sum_next;
    logic signed [SW-1:0] alpha_e, beta_e, gamma_e, psi_e, phi_e;
    logic signed [SW-1:0] hip_wrap_reg, thigh_wrap_reg, knee_wrap_reg;
    logic bad_60_reg, bad_61_reg;
    logic signed [SW-1:0] hip_rnd, thigh_rnd, knee_rnd;
    logic signed [15:0] hip_out_reg, thigh_out_reg, knee_out_reg;
    logic unreach_out_reg;

    function automatic logic signed [SW-1:0] wrap_pi(input logic signed [SW-1:0] a);
        logic signed [SW-1:0] v;
        v = a;
        if (v >= lik_pkg::PI_Q16)
        begin
            v = v - lik_pkg::TWO_PI_Q16;
        end
        if (v >= lik_pkg::PI_Q16)
        begin
            v = v - lik_pkg::TWO_PI_Q16;
        end
        if (v < -lik_pkg::PI_Q16)
        begin
            v = v + lik_pkg::TWO_PI_Q16;
        end
        return v;
    endfunction

    assign busy = 1'b0;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hip_len_reg   <= lik_pkg::HIP_RESET;
            thigh_len_reg <= lik_pkg::THIGH_RESET;
            calf_len_reg  <= lik_pkg::CALF_RESET;
        end
        else if (cfg_we)
        begin
            case (lik_pkg::cfg_index_t'(cfg_index))
                lik_pkg::CFG_HIP:   hip_len_reg   <= cfg_data;
                lik_pkg::CFG_THIGH: thigh_len_reg <= cfg_data;
                lik_pkg::CFG_CALF:  calf_len_reg  <= cfg_data;
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[lik_pkg::LATENCY-2:0], start & ~busy};
        end
    end

    always_comb
    begin
        xx_full = foot_x * foot_x;
        yy_full = foot_y * foot_y;
        zz_full = foot_z * foot_z;
    end

    always_comb
    begin
        side3_next = side2_reg;
        side3_next.bad = (ryz2_2_reg < {8'b0, h2_2_reg});
    end

    // clamp the knee cosine numerator to +-2tc
    always_comb
    begin
        side4_next = side3_reg;
        if (n_3_reg > $signed({9'b0, d_3_reg}))
        begin
            side4_next.n   = $signed({2'b0, d_3_reg});
            side4_next.bad = 1'b1;
        end
        else if (n_3_reg < -$signed({9'b0, d_3_reg}))
        begin
            side4_next.n   = -$signed({2'b0, d_3_reg});
            side4_next.bad = 1'b1;
        end
        else
        begin
            side4_next.n = 35'(n_3_reg);
        end
    end

    always_comb
    begin
        dm_full = $signed({2'b0, d_4_reg}) - side4_reg.n;
        dp_full = $signed({2'b0, d_4_reg}) + side4_reg.n;
    end

    always_ff @(posedge clk)
    begin
        side1_reg.x     <= foot_x;
        side1_reg.y     <= foot_y;
        side1_reg.z     <= foot_z;
        side1_reg.right <= is_right;
        side1_reg.h     <= hip_len_reg;
        side1_reg.t2    <= thigh_len_reg * thigh_len_reg;
        side1_reg.n     <= '0;
        side1_reg.bad   <= 1'b0;
        xx1_reg  <= xx_full[38:0];
        yy1_reg  <= yy_full[38:0];
        zz1_reg  <= zz_full[38:0];
        h2_1_reg <= hip_len_reg * hip_len_reg;
        c2_1_reg <= calf_len_reg * calf_len_reg;
        tc1_reg  <= thigh_len_reg * calf_len_reg;

        side2_reg  <= side1_reg;
        ryz2_2_reg <= {1'b0, yy1_reg} + {1'b0, zz1_reg};
        r2_2_reg   <= {2'b0, yy1_reg} + {2'b0, zz1_reg} + {2'b0, xx1_reg};
        hsum_2_reg <= {2'b0, h2_1_reg} + {2'b0, side1_reg.t2} + {2'b0, c2_1_reg};
        d_2_reg    <= {tc1_reg, 1'b0};
        h2_2_reg   <= h2_1_reg;

        side3_reg  <= side3_next;
        radw_3_reg <= side3_next.bad ? '0 : (ryz2_2_reg - {8'b0, h2_2_reg});
        n_3_reg    <= $signed({8'b0, hsum_2_reg}) - $signed({1'b0, r2_2_reg});
        d_3_reg    <= d_2_reg;

        side4_reg  <= side4_next;
        radw_4_reg <= radw_3_reg;
        d_4_reg    <= d_3_reg;

        side5_reg  <= side4_reg;
        radw_5_reg <= radw_4_reg;
        dm_5_reg   <= dm_full[33:2];
        dp_5_reg   <= dp_full[33:2];

        prod_6_reg <= dm_5_reg * dp_5_reg;
        radw_6_reg <= radw_5_reg;
    end

    // side data rides along the sqrt and cordic chains
    always_ff @(posedge clk)
    begin
        side_pipe[0] <= side5_reg;
        for (int i = 1; i < lik_pkg::SIDE_DEPTH; i++)
        begin
            side_pipe[i] <= side_pipe[i-1];
        end
    end

    assign side_a = side_pipe[lik_pkg::SQRT_STEPS];
    assign side_z = side_pipe[lik_pkg::SIDE_DEPTH-1];

    lik_sqrt u_sqrt_s (
        .clk      (clk),
        .radicand (prod_6_reg),
        .root     (s_root)
    );

    lik_sqrt u_sqrt_w (
        .clk      (clk),
        .radicand ({24'b0, radw_6_reg}),
        .root     (w_root)
    );

    always_comb
    begin
        w_val   = w_root[19:0];
        al_y    = $signed({16'b0, w_val});
        al_x    = $signed({20'b0, side_a.h});
        be_y    = AW'(side_a.z);
        be_x    = AW'(side_a.y);
        ga_y    = $signed({4'b0, s_root});
        ga_x    = AW'(side_a.n >>> 2);
        psi_num = $signed({3'b0, side_a.t2, 1'b0}) - AW'(side_a.n);
        ps_y    = -$signed({4'b0, s_root});
        ps_x    = psi_num >>> 2;
        ph_y    = AW'(side_a.x);
        ph_x    = -$signed({16'b0, w_val});
    end

    lik_atan2 u_alpha (.clk(clk), .y_in(al_y), .x_in(al_x), .angle(alpha));
    lik_atan2 u_beta  (.clk(clk), .y_in(be_y), .x_in(be_x), .angle(beta));
    lik_atan2 u_gamma (.clk(clk), .y_in(ga_y), .x_in(ga_x), .angle(gamma_a));
    lik_atan2 u_psi   (.clk(clk), .y_in(ps_y), .x_in(ps_x), .angle(psi));
    lik_atan2 u_phi   (.clk(clk), .y_in(ph_y), .x_in(ph_x), .angle(phi));

    always_comb
    begin
        alpha_e = SW'(alpha);
        beta_e  = SW'(beta);
        gamma_e = SW'(gamma_a);
        psi_e   = SW'(psi);
        phi_e   = SW'(phi);
        if (side_z.right)
        begin
            hip_sum_next = lik_pkg::PI_Q16 - alpha_e + beta_e;
        end
        else
        begin
            hip_sum_next = alpha_e + beta_e;
        end
        thigh_sum_next = lik_pkg::PI_Q16 - psi_e + phi_e;
        knee_sum_next  = gamma_e - lik_pkg::PI_Q16;
    end

    // rounding q.16 to q3.13
    always_comb
    begin
        hip_rnd   = hip_wrap_reg + SW'(4);
        thigh_rnd = thigh_wrap_reg + SW'(4);
        knee_rnd  = knee_wrap_reg + SW'(4);
    end

    always_ff @(posedge clk)
    begin
        hip_sum_reg    <= hip_sum_next;
        thigh_sum_reg  <= thigh_sum_next;
        knee_sum_reg   <= knee_sum_next;
        bad_60_reg     <= side_z.bad;
        hip_wrap_reg   <= wrap_pi(hip_sum_reg);
        thigh_wrap_reg <= wrap_pi(thigh_sum_reg);
        knee_wrap_reg  <= wrap_pi(knee_sum_reg);
        bad_61_reg     <= bad_60_reg;
        hip_out_reg     <= hip_rnd[18:3];
        thigh_out_reg   <= thigh_rnd[18:3];
        knee_out_reg    <= knee_rnd[18:3];
        unreach_out_reg <= bad_61_reg;
    end

    assign done        = vld_reg[lik_pkg::LATENCY-1];
    assign hip_angle   = hip_out_reg;
    assign thigh_angle = thigh_out_reg;
    assign knee_angle  = knee_out_reg;
    assign unreachable = unreach_out_reg;

endmodule

// ----- dv/testbench.sv -----
// self-checking testbench for leg_inverse_kinematics: directed table, then random beats
// predicts each foot target with a fixed-point ik model of its own; depends on lik_pkg
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint PI_Q = 205887;
    localparam longint HALF_PI_Q = 102944;

    typedef struct {
        logic signed [15:0] hip;
        logic signed [15:0] thigh;
        logic signed [15:0] knee;
        logic               unr;
    } joint_set_t;

    typedef struct {
        logic signed [19:0] x;
        logic signed [19:0] y;
        logic signed [19:0] z;
        logic               right;
        int                 unr;  // -1 when only the predictor decides
    } foot_row_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic signed [19:0] foot_x;
    logic signed [19:0] foot_y;
    logic signed [19:0] foot_z;
    logic               is_right;
    logic               done;
    logic signed [15:0] hip_angle;
    logic signed [15:0] thigh_angle;
    logic signed [15:0] knee_angle;
    logic               unreachable;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [15:0]        cfg_data;

    leg_inverse_kinematics dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .foot_x(foot_x), .foot_y(foot_y), .foot_z(foot_z), .is_right(is_right),
        .done(done), .hip_angle(hip_angle), .thigh_angle(thigh_angle),
        .knee_angle(knee_angle), .unreachable(unreachable),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    longint     link_hip;
    longint     link_thigh;
    longint     link_calf;
    joint_set_t pending_joints[$];
    int         pending_unr[$];
    int         errors;
    int         beats_sent;
    int         beats_checked;
    int         unreach_seen;
    int         idle_pct;
    foot_row_t  next_row;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("== FAIL ==");
        $finish;
    end

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint abs64(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint arctan_q16(longint y, longint x);
        longint atan_step[17] = '{51472, 30385, 16055, 8150, 4091, 2047, 1024, 512,
                                  256, 128, 64, 32, 16, 8, 4, 2, 1};
        longint m;
        longint acc;
        longint t;
        longint nx;
        longint ny;
        acc = 0;
        if (x == 0 && y == 0)
            return 0;
        m = abs64(x) > abs64(y) ? abs64(x) : abs64(y);
        while (m >= (64'sd1 <<< 31))
        begin
            x = x >>> 1;
            y = y >>> 1;
            m = abs64(x) > abs64(y) ? abs64(x) : abs64(y);
        end
        while (m < (64'sd1 <<< 30))
        begin
            x = x * 2;
            y = y * 2;
            m = m * 2;
        end
        // fold the left half plane onto the right
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y;
                y = -t;
                acc = HALF_PI_Q;
            end
            else
            begin
                x = -y;
                y = t;
                acc = -HALF_PI_Q;
            end
        end
        for (int i = 0; i < 17; i++)
        begin
            if (y > 0)
            begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                acc = acc + atan_step[i];
            end
            else
            begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                acc = acc - atan_step[i];
            end
            x = nx;
            y = ny;
        end
        return acc;
    endfunction

    function automatic logic signed [15:0] wrap_round(longint a);
        longint r;
        while (a >= PI_Q)
            a = a - 2 * PI_Q;
        while (a < -PI_Q)
            a = a + 2 * PI_Q;
        r = (a + 4) >>> 3;
        return r[15:0];
    endfunction

    function automatic joint_set_t solve_leg(foot_row_t f);
        joint_set_t j;
        longint x;
        longint y;
        longint z;
        longint h2;
        longint t2;
        longint c2;
        longint ryz2;
        longint r2;
        longint d;
        longint n;
        longint w;
        longint alpha;
        longint beta;
        longint gamma;
        longint psi;
        longint hip;
        longint s;
        longint unsigned lo;
        longint unsigned hi;
        logic bad;
        x = f.x;
        y = f.y;
        z = f.z;
        bad = 1'b0;
        h2 = link_hip * link_hip;
        t2 = link_thigh * link_thigh;
        c2 = link_calf * link_calf;
        ryz2 = y * y + z * z;
        r2 = ryz2 + x * x;
        d = 2 * link_thigh * link_calf;
        // foot inside the hip offset circle clamps the radicand
        if (ryz2 < h2)
        begin
            bad = 1'b1;
            w = 0;
        end
        else
            w = longint'(int_sqrt(longint'(ryz2 - h2)));
        alpha = arctan_q16(w, link_hip);
        beta = arctan_q16(z, y);
        hip = f.right ? PI_Q - alpha + beta : alpha + beta;
        n = h2 + t2 + c2 - r2;
        if (n > d)
        begin
            n = d;
            bad = 1'b1;
        end
        if (n < -d)
        begin
            n = -d;
            bad = 1'b1;
        end
        lo = longint'(d - n) >> 2;
        hi = longint'(d + n) >> 2;
        s = longint'(int_sqrt(lo * hi));
        gamma = arctan_q16(s, n >>> 2);
        psi = arctan_q16(-s, (2 * t2 - n) >>> 2);
        j.hip = wrap_round(hip);
        j.knee = wrap_round(gamma - PI_Q);
        j.thigh = wrap_round(PI_Q - psi + arctan_q16(x, -w));
        j.unr = bad;
        return j;
    endfunction

    // accepted beats are predicted here; done beats checked against the oldest
    always @(posedge clk)
    begin
        joint_set_t e;
        foot_row_t f;
        int want_unr;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                f.x = foot_x;
                f.y = foot_y;
                f.z = foot_z;
                f.right = is_right;
                f.unr = -1;
                pending_joints = {pending_joints, solve_leg(f)};
            end
            if (done)
            begin
                if (pending_joints.size() == 0)
                begin
                    $error("result beat with nothing expected");
                    errors++;
                end
                else
                begin
                    e = pending_joints.pop_front();
                    want_unr = pending_unr.pop_front();
                    beats_checked++;
                    if (unreachable)
                        unreach_seen++;
                    if (hip_angle !== e.hip)
                    begin
                        $error("hip_angle exp %0d got %0d", e.hip, hip_angle);
                        errors++;
                    end
                    if (thigh_angle !== e.thigh)
                    begin
                        $error("thigh_angle exp %0d got %0d", e.thigh, thigh_angle);
                        errors++;
                    end
                    if (knee_angle !== e.knee)
                    begin
                        $error("knee_angle exp %0d got %0d", e.knee, knee_angle);
                        errors++;
                    end
                    if (unreachable !== e.unr)
                    begin
                        $error("unreachable exp %0b got %0b", e.unr, unreachable);
                        errors++;
                    end
                    if (want_unr >= 0 && unreachable !== want_unr[0])
                    begin
                        $error("unreachable exp %0d got %0b", want_unr, unreachable);
                        errors++;
                    end
                end
            end
        end
    end

    task automatic send_foot(foot_row_t f);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        foot_x <= f.x;
        foot_y <= f.y;
        foot_z <= f.z;
        is_right <= f.right;
        pending_unr = {pending_unr, f.unr};
        forever
        begin
            @(negedge clk);
            if (!busy)
                break;
            @(posedge clk);
        end
        @(posedge clk);
        beats_sent++;
    endtask

    task automatic drain;
        start <= 1'b0;
        while (pending_joints.size() != 0)
            @(posedge clk);
        repeat (lik_pkg::LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_links(logic [15:0] h, logic [15:0] t, logic [15:0] c);
        lik_pkg::cfg_index_t idx[3] = '{lik_pkg::CFG_HIP, lik_pkg::CFG_THIGH,
                                        lik_pkg::CFG_CALF};
        logic [15:0] val[3];
        val[0] = h;
        val[1] = t;
        val[2] = c;
        for (int i = 0; i < 3; i++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= val[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        link_hip = h;
        link_thigh = t;
        link_calf = c;
    endtask

    function automatic foot_row_t random_foot();
        foot_row_t f;
        int sel;
        sel = $urandom_range(9);
        f.unr = -1;
        f.right = 1'($urandom_range(1));
        if (sel < 6)
        begin
            // mostly targets inside a plausible workspace
            f.x = $signed(20'($urandom_range(60000))) - 20'sd30000;
            f.y = $signed(20'($urandom_range(60000))) - 20'sd30000;
            f.z = -$signed(20'($urandom_range(40000)));
        end
        else if (sel < 9)
        begin
            f.x = 20'($urandom);
            f.y = 20'($urandom);
            f.z = 20'($urandom);
        end
        else
        begin
            f.x = $urandom_range(1) ? 20'sh7ffff : 20'sh80000;
            f.y = $urandom_range(1) ? 20'sd0 : 20'($urandom);
            f.z = $urandom_range(1) ? 20'sh80000 : 20'sd1;
        end
        return f;
    endfunction

    foot_row_t directed[20] = '{
        '{20'sd0, 20'sd0, 20'sd0, 1'b0, 1},
        '{20'sd0, 20'sd0, 20'sd0, 1'b1, 1},
        '{20'sh7ffff, 20'sh7ffff, 20'sh7ffff, 1'b0, 1},
        '{20'sh80000, 20'sh80000, 20'sh80000, 1'b1, 1},
        '{20'sh7ffff, 20'sd0, 20'sd0, 1'b0, 1},
        '{20'sd0, 20'sh80000, 20'sd0, 1'b1, 1},
        '{20'sd0, 20'sd0, 20'sh80000, 1'b0, 1},
        '{20'sd0, 20'sd5243, 20'sd0, 1'b0, -1},
        '{20'sd0, -20'sd5243, 20'sd0, 1'b1, -1},
        '{20'sd0, 20'sd5243, -20'sd19000, 1'b0, -1},
        '{20'sd0, -20'sd5243, -20'sd19000, 1'b1, -1},
        '{20'sd3000, 20'sd5243, -20'sd17000, 1'b0, -1},
        '{-20'sd3000, -20'sd5243, -20'sd17000, 1'b1, -1},
        '{20'sd0, 20'sd5243, -20'sd27918, 1'b0, -1},
        '{20'sd0, 20'sd5243, -20'sd27919, 1'b0, -1},
        '{20'sd0, 20'sd5243, -20'sd300, 1'b1, -1},
        '{20'sd10000, 20'sd0, -20'sd20000, 1'b0, -1},
        '{-20'sd10000, 20'sd8000, 20'sd12000, 1'b1, -1},
        '{20'sd1, -20'sd1, 20'sd1, 1'b0, 1},
        '{20'sd20000, -20'sd6000, -20'sd15000, 1'b1, -1}
    };

    initial
    begin
        logic [15:0] links[7][3];
        errors = 0;
        beats_sent = 0;
        beats_checked = 0;
        unreach_seen = 0;
        idle_pct = 0;
        rst_n = 1'b0;
        start = 1'b0;
        foot_x = '0;
        foot_y = '0;
        foot_z = '0;
        is_right = 1'b0;
        cfg_we = 1'b0;
        cfg_index = lik_pkg::CFG_HIP;
        cfg_data = '0;
        link_hip = lik_pkg::HIP_RESET;
        link_thigh = lik_pkg::THIGH_RESET;
        link_calf = lik_pkg::CALF_RESET;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_foot(directed[i]);
        drain();

        links = '{
            '{lik_pkg::HIP_RESET, lik_pkg::THIGH_RESET, lik_pkg::CALF_RESET},
            '{16'd1, 16'd1, 16'd1},
            '{16'hffff, 16'hffff, 16'hffff},
            '{16'd1, 16'hffff, 16'd1},
            '{16'hffff, 16'd1, 16'hffff},
            '{16'd3000, 16'd20000, 16'd18000},
            '{16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
              16'($urandom_range(1, 65535))}
        };
        for (int p = 0; p < 7; p++)
        begin
            write_links(links[p][0], links[p][1], links[p][2]);
            for (int i = 0; i < 100; i++)
            begin
                // sender idles a little, then often, then not at all
                idle_pct = (i < 34) ? 12 : (i < 67) ? 46 : 0;
                next_row = random_foot();
                send_foot(next_row);
            end
            drain();
        end

        $display("sent %0d foot targets over 7 link settings, checked %0d joint sets",
                 beats_sent, beats_checked);
        $display("%0d of them flagged out of reach", unreach_seen);
        if (errors == 0 && pending_joints.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/lik_pkg.sv
rtl/lik_sqrt_cell.sv
rtl/lik_sqrt.sv
rtl/lik_cordic_cell.sv
rtl/lik_atan2.sv
rtl/leg_inverse_kinematics.sv
dv/testbench.sv
